// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ETF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ETF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg
// shared types, widths and helpers of the escape-time pixel engine
// ----------------------------------------------------------------------------
package etf_pkg;

	localparam int ZW        = 32;
	localparam int FRAC_BITS = 28;
	localparam int PROD_W    = 2 * ZW;
	localparam int ROW_W     = 10;
	localparam int COL_W     = 10;
	localparam int CNT_W     = 11;
	localparam int GRAY_W    = 8;
	localparam int CPROD_W   = ZW + COL_W + 1;
	localparam int DIV_CELLS = GRAY_W;
	localparam int DIV_W     = CNT_W + GRAY_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [CNT_W-1:0]  ITER_CAP = CNT_W'(1024);
	localparam logic [GRAY_W-1:0] GRAY_MAX = GRAY_W'(255);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_ORIGIN = 3'd0,
		REG_ROW_STEP   = 3'd1,
		REG_COL_ORIGIN = 3'd2,
		REG_COL_STEP   = 3'd3,
		REG_START_REAL = 3'd4,
		REG_START_IMAG = 3'd5,
		REG_ESC_RAD_SQ = 3'd6,
		REG_MAX_ITER   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [ZW-1:0] cr;
		logic signed [ZW-1:0] ci;
		logic signed [ZW-1:0] zr;
		logic signed [ZW-1:0] zi;
		logic [CNT_W-1:0]     limit;
	} iter_init_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] count;
	} iter_res_t;

	typedef struct packed {
		logic              valid;
		logic [DIV_W-1:0]  rem;
		logic [DIV_W-1:0]  div;
		logic [GRAY_W-1:0] quo;
	} div_cell_t;

	function automatic logic signed [ZW-1:0] sat_z(input logic signed [PROD_W-1:0] x);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'({1'b0, {(ZW-1){1'b1}}});
		lo = -hi - PROD_W'(1);
		if (x > hi) begin
			sat_z = hi[ZW-1:0];
		end else if (x < lo) begin
			sat_z = lo[ZW-1:0];
		end else begin
			sat_z = x[ZW-1:0];
		end
	endfunction

endpackage

// File: hw/rtl/etf_div_cell.sv
// ----------------------------------------------------------------------------
// etf_div_cell
// one restoring-division step: compare, subtract, shift divisor to neighbor
// ----------------------------------------------------------------------------
module etf_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  etf_pkg::div_cell_t din,
	output etf_pkg::div_cell_t dout
);
	import etf_pkg::*;

	logic              valid_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  div_q;
	logic [GRAY_W-1:0] quo_q;
	logic              ge;

	assign ge = din.rem >= din.div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= ge ? din.rem - din.div : din.rem;
		div_q <= din.div >> 1;
		quo_q <= {din.quo[GRAY_W-2:0], ge};
	end

	assign dout = '{valid: valid_q, rem: rem_q, div: div_q, quo: quo_q};

endmodule

// File: hw/rtl/etf_iter_unit.sv
// ----------------------------------------------------------------------------
// etf_iter_unit
// shared complex square-and-add unit: a multiply state, then an evaluate state, per iteration
// ----------------------------------------------------------------------------
module etf_iter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  etf_pkg::iter_init_t init,
	input  logic [31:0]         escape_radius_sq,
	output etf_pkg::iter_res_t  res
);
	import etf_pkg::*;

	typedef enum logic [2:0] {
		IT_IDLE = 3'b001,
		IT_MUL  = 3'b010,
		IT_EVAL = 3'b100
	} it_state_t;

	it_state_t                state_q;
	logic signed [ZW-1:0]     zr_q, zi_q, cr_q, ci_q;
	logic [CNT_W-1:0]         count_q, limit_q;
	logic signed [PROD_W-1:0] rr_q, ii_q, ri_q;
	logic [PROD_W-1:0]        mag;
	logic                     in_radius, cont;
	logic signed [PROD_W-1:0] nr_sum, ni_sum;

	assign mag       = $unsigned(rr_q) + $unsigned(ii_q);
	assign in_radius = mag <= {{(PROD_W-ZW-FRAC_BITS){1'b0}}, escape_radius_sq, {FRAC_BITS{1'b0}}};
	assign cont      = (count_q < limit_q) && in_radius;

	// floor shift of the sum equals floor shift plus c
	assign nr_sum = rr_q - ii_q + (PROD_W'(cr_q) <<< FRAC_BITS);
	assign ni_sum = ri_q + (PROD_W'(ci_q) <<< (FRAC_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IT_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				IT_IDLE: begin
					if (start) begin
						state_q <= IT_MUL;
						count_q <= CNT_W'(1);
					end
				end
				IT_MUL: begin
					state_q <= IT_EVAL;
				end
				IT_EVAL: begin
					if (cont) begin
						state_q <= IT_MUL;
						count_q <= count_q + CNT_W'(1);
					end else begin
						state_q <= IT_IDLE;
					end
				end
				default: begin
					state_q <= IT_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IT_IDLE && start) begin
			zr_q    <= init.zr;
			zi_q    <= init.zi;
			cr_q    <= init.cr;
			ci_q    <= init.ci;
			limit_q <= init.limit;
		end
		if (state_q == IT_MUL) begin
			rr_q <= zr_q * zr_q;
			ii_q <= zi_q * zi_q;
			ri_q <= zr_q * zi_q;
		end
		if (state_q == IT_EVAL && cont) begin
			zr_q <= sat_z(nr_sum >>> FRAC_BITS);
			zi_q <= sat_z(ni_sum >>> (FRAC_BITS - 1));
		end
	end

	assign res = '{done: (state_q == IT_EVAL) && !cont, count: count_q};

endmodule

// File: hw/rtl/escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// escape-time pixel engine: maps a pixel to a complex point, iterates
// z = z*z + c and returns the iteration count and a gray level
// ----------------------------------------------------------------------------
// usage
//   s_* carries one pixel (row, column); m_* returns row, column, count and
//   gray level. cfg_* writes the eight window/limit registers; the user must
//   write them only while idle, as the block does not enforce this. one pixel
//   is in flight at a time; s_tready is high only when idle.
//   from input to m_tvalid, the CMUL and CSAT states form c, the shared
//   multiply/evaluate unit runs each count step (three 32x32 products, then
//   add, compare and saturate), an eight-cell division chain forms the gray
//   level and the output register is loaded.
//   the result sits in an output register: the next pixel is taken while it
//   waits; if m_tready stays low the finished result of the next pixel waits
//   in the engine and no further pixel is taken.
//   reset clears m_tvalid, returns the sequencer to idle and loads the
//   register defaults (escape radius squared 4.0, limit 256, all else 0).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module escape_time_fractal_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pixel_row, pixel_col
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_row, out_col, iteration_count, gray_level
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import etf_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CMUL = 6'b000010,
		ST_CSAT = 6'b000100,
		ST_ITER = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_HOLD = 6'b100000
	} state_t;

	state_t                    state_q;
	logic signed [ZW-1:0]      row_origin_q, row_step_q, col_origin_q, col_step_q;
	logic signed [ZW-1:0]      start_real_q, start_imag_q;
	logic [ZW-1:0]             esc_rad_sq_q;
	logic [CNT_W-1:0]          max_iter_q;
	logic [ROW_W-1:0]          row_q, out_row_q;
	logic [COL_W-1:0]          col_q, out_col_q;
	logic [CNT_W-1:0]          limit_q, cnt_q, out_cnt_q;
	logic [GRAY_W-1:0]         gray_q, out_gray_q;
	logic signed [CPROD_W-1:0] pc_q, pr_q;
	logic                      m_tvalid_q;
	logic                      out_load;
	iter_init_t                iter_init;
	iter_res_t                 iter_res;
	div_cell_t                 div_link [DIV_CELLS+1];

	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {1'b0, out_gray_q, out_cnt_q, out_col_q, out_row_q};
	assign out_load  = (state_q == ST_HOLD) && (!m_tvalid_q || m_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_origin_q <= '0;
			row_step_q   <= '0;
			col_origin_q <= '0;
			col_step_q   <= '0;
			start_real_q <= '0;
			start_imag_q <= '0;
			esc_rad_sq_q <= ZW'(32'h4000_0000);
			max_iter_q   <= CNT_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_ORIGIN: row_origin_q <= cfg_data;
				REG_ROW_STEP:   row_step_q   <= cfg_data;
				REG_COL_ORIGIN: col_origin_q <= cfg_data;
				REG_COL_STEP:   col_step_q   <= cfg_data;
				REG_START_REAL: start_real_q <= cfg_data;
				REG_START_IMAG: start_imag_q <= cfg_data;
				REG_ESC_RAD_SQ: esc_rad_sq_q <= cfg_data;
				REG_MAX_ITER:   max_iter_q   <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CMUL;
					end
				end
				ST_CMUL: begin
					state_q <= ST_CSAT;
				end
				ST_CSAT: begin
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					if (iter_res.done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_link[DIV_CELLS].valid) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			row_q   <= s_tdata[ROW_W-1:0];
			col_q   <= s_tdata[ROW_W+COL_W-1:ROW_W];
			limit_q <= (max_iter_q < ITER_CAP) ? max_iter_q : ITER_CAP;
		end
		if (state_q == ST_CMUL) begin
			pc_q <= col_step_q * $signed({1'b0, col_q});
			pr_q <= row_step_q * $signed({1'b0, row_q});
		end
		if (iter_res.done) begin
			cnt_q <= iter_res.count;
		end
		if (state_q == ST_DIV && div_link[DIV_CELLS].valid) begin
			gray_q <= (cnt_q >= limit_q) ? '0 : GRAY_MAX - div_link[DIV_CELLS].quo;
		end
		if (out_load) begin
			out_row_q  <= row_q;
			out_col_q  <= col_q;
			out_cnt_q  <= cnt_q;
			out_gray_q <= gray_q;
		end
	end

	assign iter_init = '{
		cr:    sat_z(PROD_W'(col_origin_q) + PROD_W'(pc_q)),
		ci:    sat_z(PROD_W'(row_origin_q) + PROD_W'(pr_q)),
		zr:    start_real_q,
		zi:    start_imag_q,
		limit: limit_q
	};

	etf_iter_unit u_iter (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (state_q == ST_CSAT),
		.init             (iter_init),
		.escape_radius_sq (esc_rad_sq_q),
		.res              (iter_res)
	);

	// count*255 / limit, one quotient bit per cell
	assign div_link[0] = '{
		valid: iter_res.done,
		rem:   DIV_W'(iter_res.count) * DIV_W'(GRAY_MAX),
		div:   DIV_W'({limit_q, {(DIV_CELLS-1){1'b0}}}),
		quo:   '0
	};

	for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
		etf_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (div_link[g]),
			.dout   (div_link[g+1])
		);
	end

	`ETF_ASSERT_IMP(a_done_in_iter, iter_res.done, state_q == ST_ITER, "iteration finished outside iterate state")
	`ETF_ASSERT_IMP(a_div_in_div, div_link[DIV_CELLS].valid, state_q == ST_DIV, "division result outside divide state")
	`ETF_ASSERT_IMP(a_count_bound, iter_res.done, iter_res.count <= limit_q || iter_res.count == CNT_W'(1), "count beyond limit")
	`ETF_ASSERT_NXT(a_hold_release, out_load, state_q == ST_IDLE && m_tvalid, "result not presented after hold")

endmodule

// File: dv/escape_time_fractal_pixel_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_test
// self-checking bench for the escape-time pixel engine: a fixed list of
// register writes and pixels covers the limit, cap, radius and saturation
// corners, then random windows with random pixels run under four idling
// patterns; every result is compared with a fixed-point escape-count model,
// whose count and gray level typed plan steps replace with their own values
module escape_time_fractal_pixel_test;

	import etf_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [9:0]  row;
		logic [9:0]  col;
		logic [10:0] count;
		logic [7:0]  gray;
	} pixel_result_t;

	typedef struct {
		logic signed [31:0] row_origin;
		logic signed [31:0] row_step;
		logic signed [31:0] col_origin;
		logic signed [31:0] col_step;
		logic signed [31:0] start_re;
		logic signed [31:0] start_im;
		logic [31:0]        esc_rsq;
		logic [10:0]        max_iter;
	} window_t;

	typedef struct packed {
		logic        is_write;
		cfg_reg_t    reg_sel;
		logic [31:0] value;
		logic [9:0]  row;
		logic [9:0]  col;
		logic        typed;
		logic [10:0] count;
		logic [7:0]  gray;
	} plan_step_t;

	localparam int PLAN_LEN = 37;
	localparam plan_step_t PLAN [PLAN_LEN] = '{
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd0,    10'd0,    1'b1, 11'd256,  8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd1023, 10'd1023, 1'b1, 11'd256,  8'd0},
		'{1'b1, REG_MAX_ITER,   32'd1,         10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd5,    10'd7,    1'b1, 11'd1,    8'd0},
		'{1'b1, REG_MAX_ITER,   32'd0,         10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd1023, 10'd0,    1'b1, 11'd1,    8'd0},
		'{1'b1, REG_MAX_ITER,   32'd2047,      10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd0,    10'd1023, 1'b1, 11'd1024, 8'd0},
		'{1'b1, REG_MAX_ITER,   32'd16,        10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_ESC_RAD_SQ, 32'h0,         10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_START_REAL, 32'h1000_0000, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd3,    10'd9,    1'b1, 11'd1,    8'd240},
		'{1'b1, REG_START_REAL, 32'h0,         10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd9,    10'd3,    1'b1, 11'd16,   8'd0},
		'{1'b1, REG_ESC_RAD_SQ, 32'hFFFF_FFFF, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_COL_ORIGIN, 32'h7FFF_FFFF, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_COL_STEP,   32'h7FFF_FFFF, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_ROW_ORIGIN, 32'h8000_0000, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_ROW_STEP,   32'h8000_0000, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_START_IMAG, 32'h7FFF_FFFF, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_START_REAL, 32'h8000_0000, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_MAX_ITER,   32'd1024,      10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd1023, 10'd1023, 1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd512,  10'd1,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_COL_ORIGIN, 32'hE000_0000, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_COL_STEP,   32'h000C_0000, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_ROW_ORIGIN, 32'hE800_0000, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_ROW_STEP,   32'h000C_0000, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_START_REAL, 32'h0,         10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_START_IMAG, 32'h0,         10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_ESC_RAD_SQ, 32'h4000_0000, 10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b1, REG_MAX_ITER,   32'd64,        10'd0,    10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd512,  10'd682,  1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd512,  10'd0,    1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd0,    10'd1023, 1'b0, 11'd0,    8'd0},
		'{1'b0, REG_ROW_ORIGIN, 32'h0,         10'd300,  10'd500,  1'b0, 11'd0,    8'd0}
	};

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 48;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;     // pixel_row, pixel_col
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // out_row, out_col, iteration_count, gray_level
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_ROW_ORIGIN;
	logic [31:0] cfg_data = '0;

	window_t       win;
	idle_mode_t    idle_mode = IDLE_NONE;
	pixel_result_t pending_pixels [$];
	int            n_pixels = 0;
	int            n_results = 0;
	int            n_writes = 0;
	int            mismatches = 0;

	escape_time_fractal_pixel u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint clamp_q(input longint x);
		if (x > longint'(32'sh7FFF_FFFF)) begin
			return longint'(32'sh7FFF_FFFF);
		end else if (x < -longint'(32'sh7FFF_FFFF) - 1) begin
			return -longint'(32'sh7FFF_FFFF) - 1;
		end
		return x;
	endfunction

	function automatic pixel_result_t compute_pixel(input logic [9:0] row, input logic [9:0] col);
		pixel_result_t res;
		longint        cr, ci, zr, zi, rr, ii, ri;
		bit [63:0]     ar, ai, mag;
		int unsigned   lim, cnt;
		bit            escaped;
		lim = (win.max_iter < 11'd1024) ? win.max_iter : 1024;
		cr = clamp_q(longint'(win.col_origin) + longint'(col) * longint'(win.col_step));
		ci = clamp_q(longint'(win.row_origin) + longint'(row) * longint'(win.row_step));
		zr = longint'(win.start_re);
		zi = longint'(win.start_im);
		cnt = 1;
		escaped = 1'b0;
		while (cnt < lim && !escaped) begin
			ar = (zr < 0) ? -zr : zr;
			ai = (zi < 0) ? -zi : zi;
			mag = ar * ar + ai * ai;
			if ((mag >> FRAC_BITS) > win.esc_rsq ||
			    ((mag >> FRAC_BITS) == win.esc_rsq && mag[FRAC_BITS-1:0] != 0)) begin
				escaped = 1'b1;
			end else begin
				rr = zr * zr;
				ii = zi * zi;
				ri = zr * zi;
				zr = clamp_q(((rr - ii) >>> FRAC_BITS) + cr);
				zi = clamp_q((ri >>> (FRAC_BITS - 1)) + ci);
				cnt++;
			end
		end
		res.row = row;
		res.col = col;
		res.count = cnt[10:0];
		res.gray = (cnt >= lim) ? 8'd0 : 8'(255 - (cnt * 255) / lim);
		return res;
	endfunction

	function automatic int stall_pct(input bit sender);
		case (idle_mode)
			IDLE_SEND: return sender ? 70 : 0;
			IDLE_RECV: return sender ? 0 : 70;
			IDLE_BOTH: return 17;
			default:   return 0;
		endcase
	endfunction

	task automatic write_reg(input cfg_reg_t sel, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (sel)
			REG_ROW_ORIGIN: win.row_origin = value;
			REG_ROW_STEP:   win.row_step = value;
			REG_COL_ORIGIN: win.col_origin = value;
			REG_COL_STEP:   win.col_step = value;
			REG_START_REAL: win.start_re = value;
			REG_START_IMAG: win.start_im = value;
			REG_ESC_RAD_SQ: win.esc_rsq = value;
			REG_MAX_ITER:   win.max_iter = value[10:0];
			default: ;
		endcase
		n_writes++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [9:0] row, input logic [9:0] col, input logic typed,
		input logic [10:0] cnt, input logic [7:0] gray);
		pixel_result_t want;
		int unsigned   gap;
		gap = 0;
		while ($urandom_range(0, 99) < stall_pct(1'b1)) gap++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, col, row};
		do @(posedge clk); while (!s_tready);
		want = compute_pixel(row, col);
		if (typed) begin
			want.count = cnt;
			want.gray = gray;
		end
		pending_pixels.push_back(want);
		n_pixels++;
	endtask

	task automatic load_window(input bit any_value, input logic [10:0] lim);
		logic [31:0] ro, rs, co, cs, sr, si, er, mi;
		if (any_value) begin
			ro = $urandom();
			rs = $urandom();
			co = $urandom();
			cs = $urandom();
			sr = $urandom();
			si = $urandom();
			er = $urandom();
			mi = $urandom_range(0, 2047);
		end else begin
			// window around the main cardioid, up to about two units wide
			co = 32'($urandom_range(0, 32'h1800_0000)) - 32'h2800_0000;
			ro = 32'($urandom_range(0, 32'h1000_0000)) - 32'h1400_0000;
			cs = $urandom_range(0, 32'h0008_0000);
			rs = $urandom_range(0, 32'h0008_0000);
			if ($urandom_range(0, 3) == 0) cs = -cs;
			if ($urandom_range(0, 3) == 0) rs = -rs;
			sr = '0;
			si = '0;
			if ($urandom_range(0, 3) == 0) begin
				sr = 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
				si = 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
			end
			er = 32'h4000_0000;
			if ($urandom_range(0, 3) == 0) er = $urandom_range(32'h0400_0000, 32'h4000_0000);
			mi = 32'(lim);
		end
		write_reg(REG_ROW_ORIGIN, ro);
		write_reg(REG_ROW_STEP, rs);
		write_reg(REG_COL_ORIGIN, co);
		write_reg(REG_COL_STEP, cs);
		write_reg(REG_START_REAL, sr);
		write_reg(REG_START_IMAG, si);
		write_reg(REG_ESC_RAD_SQ, er);
		write_reg(REG_MAX_ITER, mi);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct(1'b0));
	end

	always @(posedge clk) begin : result_check
		pixel_result_t want;
		pixel_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.row = m_tdata[9:0];
			got.col = m_tdata[19:10];
			got.count = m_tdata[30:20];
			got.gray = m_tdata[38:31];
			n_results++;
			if (pending_pixels.size() == 0) begin
				$display("%0t: result with no pixel pending, expected none, actual %h",
					$time, got);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("out_row", want.row, got.row);
				check_field("out_col", want.col, got.col);
				check_field("iteration_count", want.count, got.count);
				check_field("gray_level", want.gray, got.gray);
			end
		end
	end

	initial begin
		logic [10:0] lim;
		bit          any_value;
		win.row_origin = '0;
		win.row_step = '0;
		win.col_origin = '0;
		win.col_step = '0;
		win.start_re = '0;
		win.start_im = '0;
		win.esc_rsq = 32'h4000_0000;
		win.max_iter = 11'd256;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: reset values, limit below two and above the cap, radius edges,
		// saturated c and z, then a standard window
		foreach (PLAN[i]) begin
			if (PLAN[i].is_write) begin
				wait_idle();
				write_reg(PLAN[i].reg_sel, PLAN[i].value);
			end else begin
				cfg_valid <= 1'b0;
				send_pixel(PLAN[i].row, PLAN[i].col, PLAN[i].typed, PLAN[i].count,
					PLAN[i].gray);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			any_value = (p == 2 || p == 6);
			case (p)
				1:       lim = 11'($urandom_range(2, 8));
				5:       lim = 11'd1024;
				7:       lim = 11'($urandom_range(100, 256));
				default: lim = 11'($urandom_range(2, 40));
			endcase
			load_window(any_value, lim);
			idle_mode = idle_mode_t'(p % 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), 1'b0,
					'0, '0);
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		$display("%0d pixels over %0d register writes, %0d results compared", n_pixels,
			n_writes, n_results);
		$display("limits 0 to 2047, saturated windows, radius edges, four idling patterns");
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#(60_000_000);
		$display("Verification failed");
		$finish;
	end

endmodule
